@@ design/bnms_pkg.sv @@
package bnms_pkg;

	localparam int MaxBoxesDefault = 64;
	localparam int CoordWidth = 16;
	localparam int BoxWidth = 64;
	localparam int ScoreWidth = 16;
	localparam int IndexWidth = 6;
	localparam logic [15:0] ThresholdReset = 16'd32768;

	typedef struct packed {
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [15:0] box_width;
		logic [15:0] box_height;
		logic [15:0] score;
		logic        last_box;
	} box_req_t;

	typedef struct packed {
		logic [5:0] box_index;
		logic       keep;
		logic       overflow;
		logic       last_result;
	} keep_rsp_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_RANK_RD,
		ST_RANK_CMP,
		ST_RANK_WR,
		ST_SUP_RDA,
		ST_SUP_WAITA,
		ST_SUP_RDB,
		ST_SUP_RANKB,
		ST_SUP_BOXB,
		ST_SUP_CALC,
		ST_SUP_MUL,
		ST_SUP_CMP,
		ST_EMIT
	} bnms_state_t;

	typedef struct packed {
		logic [15:0] ax;
		logic [15:0] ay;
		logic [15:0] aw;
		logic [15:0] ah;
	} box_t;

endpackage

@@ design/bnms_ram.sv @@
module bnms_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ design/bnms_iou.sv @@
// Two-stage overlap test: edges and intersection sides, then products and compare.
module bnms_iou (
	input  logic              clk,
	input  logic              start,
	input  bnms_pkg::box_t    box_a,
	input  bnms_pkg::box_t    box_b,
	input  logic [15:0]       threshold,
	output logic              hit
);

	logic signed [18:0] al, ar, bl, br, at, ab, bt, bb, l, r, t, d;
	logic [17:0] iw_c, ih_c;
	logic [17:0] iw_s1, ih_s1;
	logic [31:0] aa_s1, ba_s1;
	logic [35:0] i4_s2;
	logic [33:0] area_s2;
	logic [15:0] thr_s1, thr_s2;
	logic [35:0] u4;
	logic [52:0] lhs, rhs;

	always_comb begin
		al = 19'(signed'({2'b0, box_a.ax, 1'b0})) - 19'(signed'({3'b0, box_a.aw}));
		ar = 19'(signed'({2'b0, box_a.ax, 1'b0})) + 19'(signed'({3'b0, box_a.aw}));
		bl = 19'(signed'({2'b0, box_b.ax, 1'b0})) - 19'(signed'({3'b0, box_b.aw}));
		br = 19'(signed'({2'b0, box_b.ax, 1'b0})) + 19'(signed'({3'b0, box_b.aw}));
		at = 19'(signed'({2'b0, box_a.ay, 1'b0})) - 19'(signed'({3'b0, box_a.ah}));
		ab = 19'(signed'({2'b0, box_a.ay, 1'b0})) + 19'(signed'({3'b0, box_a.ah}));
		bt = 19'(signed'({2'b0, box_b.ay, 1'b0})) - 19'(signed'({3'b0, box_b.ah}));
		bb = 19'(signed'({2'b0, box_b.ay, 1'b0})) + 19'(signed'({3'b0, box_b.ah}));
		l = (al > bl) ? al : bl;
		r = (ar < br) ? ar : br;
		t = (at > bt) ? at : bt;
		d = (ab < bb) ? ab : bb;
		iw_c = (r > l) ? 18'(r - l) : 18'd0;
		ih_c = (d > t) ? 18'(d - t) : 18'd0;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			iw_s1 <= iw_c;
			ih_s1 <= ih_c;
			aa_s1 <= 32'(box_a.aw) * 32'(box_a.ah);
			ba_s1 <= 32'(box_b.aw) * 32'(box_b.ah);
			thr_s1 <= threshold;
		end
		i4_s2 <= 36'(iw_s1) * 36'(ih_s1);
		area_s2 <= 34'(aa_s1) + 34'(ba_s1);
		thr_s2 <= thr_s1;
	end

	// The union in quad units cannot go negative: intersection never exceeds either area.
	always_comb begin
		u4 = {area_s2, 2'b00} - i4_s2;
		lhs = {1'b0, i4_s2, 16'd0};
		rhs = 53'(thr_s2) * 53'(u4);
		hit = lhs > rhs;
	end

endmodule

@@ design/box_non_max_suppression.sv @@
// Channel    | Valid          | Stall          | Payload
// request    | req_valid      | req_stall      | req (bnms_pkg::box_req_t)
// result     | rsp_valid      | rsp_stall      | rsp (bnms_pkg::keep_rsp_t)
// config     | cfg_we         | -              | cfg_data
//
// The load phase takes a box whenever req_valid is high. The closing box starts
// ranking (one score read per comparison), then suppression on the shared
// overlap unit, then one result per cycle while rsp_stall is low and a closing
// step that resets the count and keep flags. All work runs through the box,
// score and rank memories' single read ports. Reset clears control, sets every
// keep flag and loads the threshold default; stores stay undefined. A stalled
// result holds the block; input is stalled outside the load phase.
module box_non_max_suppression #(
	parameter int MaxBoxes = bnms_pkg::MaxBoxesDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  bnms_pkg::box_req_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output bnms_pkg::keep_rsp_t rsp,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data
);

	localparam int Aw = 6;
	localparam logic [6:0] Cap = 7'(MaxBoxes);

	bnms_pkg::bnms_state_t state_q, state_d;
	logic [15:0] thr_q;
	logic [6:0]  count_q;
	logic        dropped_q;
	logic [63:0] keep_q;
	logic [6:0]  i_q, j_q, pos_q;
	logic [15:0] si_q;
	logic        rsp_valid_q;
	bnms_pkg::keep_rsp_t rsp_q;
	bnms_pkg::box_t box_a_q;
	logic [Aw-1:0] kb_q;
	logic [1:0]  wait_q;

	logic        box_we, score_we, rank_we;
	logic [Aw-1:0] box_wa, box_ra, score_ra, rank_ra, rank_wa;
	logic [63:0] box_rd;
	logic [15:0] score_rd;
	logic [5:0]  rank_rd, rank_wd;
	logic        accept, hit, iou_start;
	logic        rsp_load;

	assign accept = req_valid && !req_stall;
	assign req_stall = (state_q != bnms_pkg::ST_LOAD);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign rsp_load = (state_q == bnms_pkg::ST_EMIT) && (!rsp_valid_q || !rsp_stall)
		&& (i_q != count_q);

	assign box_we = accept && (count_q < Cap);
	assign score_we = box_we;
	assign box_wa = count_q[Aw-1:0];

	bnms_ram #(.Width(bnms_pkg::BoxWidth), .Depth(64)) u_box_ram (
		.clk(clk), .wr_en(box_we), .wr_addr(box_wa),
		.wr_data({req.box_height, req.box_width, req.center_y, req.center_x}),
		.rd_addr(box_ra), .rd_data(box_rd)
	);
	bnms_ram #(.Width(bnms_pkg::ScoreWidth), .Depth(64)) u_score_ram (
		.clk(clk), .wr_en(score_we), .wr_addr(box_wa), .wr_data(req.score),
		.rd_addr(score_ra), .rd_data(score_rd)
	);
	bnms_ram #(.Width(bnms_pkg::IndexWidth), .Depth(64)) u_rank_ram (
		.clk(clk), .wr_en(rank_we), .wr_addr(rank_wa), .wr_data(rank_wd),
		.rd_addr(rank_ra), .rd_data(rank_rd)
	);

	bnms_iou u_iou (
		.clk(clk), .start(iou_start), .box_a(box_a_q),
		.box_b('{ax: box_rd[15:0], ay: box_rd[31:16], aw: box_rd[47:32],
			ah: box_rd[63:48]}),
		.threshold(thr_q), .hit(hit)
	);

	always_comb begin
		state_d = state_q;
		rank_we = 1'b0;
		rank_wa = pos_q[Aw-1:0];
		rank_wd = i_q[Aw-1:0];
		score_ra = i_q[Aw-1:0];
		rank_ra = i_q[Aw-1:0];
		box_ra = rank_rd;
		iou_start = 1'b0;
		case (state_q)
			bnms_pkg::ST_LOAD: begin
				if (accept && req.last_box) begin
					state_d = bnms_pkg::ST_RANK_RD;
				end
			end
			bnms_pkg::ST_RANK_RD: begin
				state_d = bnms_pkg::ST_RANK_CMP;
				score_ra = j_q[Aw-1:0];
			end
			bnms_pkg::ST_RANK_CMP: begin
				score_ra = (wait_q == 2'd0) ? i_q[Aw-1:0] : j_q[Aw-1:0];
				if (wait_q == 2'd2 && j_q == count_q) begin
					state_d = bnms_pkg::ST_RANK_WR;
				end
			end
			bnms_pkg::ST_RANK_WR: begin
				rank_we = 1'b1;
				state_d = (i_q + 7'd1 == count_q) ? bnms_pkg::ST_SUP_RDA
					: bnms_pkg::ST_RANK_RD;
			end
			bnms_pkg::ST_SUP_RDA: begin
				state_d = (i_q + 7'd1 >= count_q) ? bnms_pkg::ST_EMIT
					: bnms_pkg::ST_SUP_WAITA;
			end
			bnms_pkg::ST_SUP_WAITA: begin
				rank_ra = i_q[Aw-1:0];
				state_d = bnms_pkg::ST_SUP_RDB;
			end
			bnms_pkg::ST_SUP_RDB: begin
				rank_ra = j_q[Aw-1:0];
				state_d = bnms_pkg::ST_SUP_RANKB;
			end
			bnms_pkg::ST_SUP_RANKB: begin
				state_d = bnms_pkg::ST_SUP_BOXB;
			end
			bnms_pkg::ST_SUP_BOXB: begin
				iou_start = 1'b1;
				state_d = bnms_pkg::ST_SUP_CALC;
			end
			bnms_pkg::ST_SUP_CALC: state_d = bnms_pkg::ST_SUP_MUL;
			bnms_pkg::ST_SUP_MUL: state_d = bnms_pkg::ST_SUP_CMP;
			bnms_pkg::ST_SUP_CMP: begin
				if (j_q + 7'd1 == count_q) begin
					state_d = bnms_pkg::ST_SUP_RDA;
				end else begin
					state_d = bnms_pkg::ST_SUP_RDB;
				end
			end
			bnms_pkg::ST_EMIT: begin
				if ((!rsp_valid_q || !rsp_stall) && i_q == count_q) begin
					state_d = bnms_pkg::ST_LOAD;
				end
			end
			default: state_d = bnms_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bnms_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= bnms_pkg::ThresholdReset;
			count_q <= '0;
			dropped_q <= 1'b0;
			keep_q <= '1;
			i_q <= '0;
			j_q <= '0;
			pos_q <= '0;
			rsp_valid_q <= 1'b0;
			wait_q <= '0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_data;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				bnms_pkg::ST_LOAD: begin
					if (accept) begin
						if (count_q < Cap) begin
							count_q <= count_q + 7'd1;
						end else begin
							dropped_q <= 1'b1;
						end
					end
					i_q <= '0;
					j_q <= '0;
					pos_q <= '0;
				end
				bnms_pkg::ST_RANK_RD: begin
					j_q <= 7'd1;
					pos_q <= '0;
				end
				bnms_pkg::ST_RANK_CMP: begin
					// Previous read returned score j-1; the first cycle fetches score i.
					if (j_q == 7'd1 && wait_q == 2'd0) begin
						wait_q <= 2'd1;
						j_q <= 7'd0;
					end else begin
						if (wait_q == 2'd1) begin
							si_q <= score_rd;
							wait_q <= 2'd2;
						end else if (score_rd > si_q ||
							(score_rd == si_q && (j_q - 7'd1) < i_q)) begin
							pos_q <= pos_q + 7'd1;
						end
						if (j_q != count_q) begin
							j_q <= j_q + 7'd1;
						end
					end
				end
				bnms_pkg::ST_RANK_WR: begin
					wait_q <= '0;
					i_q <= (i_q + 7'd1 == count_q) ? 7'd0 : i_q + 7'd1;
				end
				bnms_pkg::ST_SUP_RDA: begin
					j_q <= i_q + 7'd1;
					if (i_q + 7'd1 >= count_q) begin
						i_q <= '0;
					end
				end
				bnms_pkg::ST_SUP_WAITA: ;
				bnms_pkg::ST_SUP_RDB: begin
					if (j_q == i_q + 7'd1) begin
						box_a_q <= '{ax: box_rd[15:0], ay: box_rd[31:16],
							aw: box_rd[47:32], ah: box_rd[63:48]};
					end
				end
				bnms_pkg::ST_SUP_RANKB: kb_q <= rank_rd;
				bnms_pkg::ST_SUP_CMP: begin
					if (hit) begin
						keep_q[kb_q] <= 1'b0;
					end
					if (j_q + 7'd1 == count_q) begin
						i_q <= i_q + 7'd1;
					end else begin
						j_q <= j_q + 7'd1;
					end
				end
				bnms_pkg::ST_EMIT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						if (i_q == count_q) begin
							count_q <= '0;
							dropped_q <= 1'b0;
							keep_q <= '1;
							i_q <= '0;
						end else begin
							rsp_q <= '{box_index: i_q[5:0], keep: keep_q[i_q[5:0]],
								overflow: dropped_q, last_result: (i_q + 7'd1 == count_q)};
							i_q <= i_q + 7'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Cap) else $error("box count above capacity");
	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != bnms_pkg::ST_LOAD) |-> !accept) else $error("request taken while busy");
	a_rsp_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == bnms_pkg::ST_EMIT)
		else $error("result outside emit phase");

endmodule
